// ----- sv/lwmc_pkg.sv -----
// shared constants, types and helpers for the local window mean and contrast block
package lwmc_pkg;

   // image store geometry and window size
   localparam int MAX_WIDTH     = 128;
   localparam int MAX_HEIGHT    = 128;
   localparam int WINDOW_RADIUS = 5;

   localparam int WIN         = 2 * WINDOW_RADIUS + 1;
   localparam int WIN_W       = $clog2(WIN);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int PIX_W       = 9;

   // signed coordinate width: covers query plus offset plus radius and the image size
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int COORD_W = ((DIM_W > 10) ? DIM_W : 10) + 1;

   // accumulator widths
   localparam int CNT_W = $clog2(WIN * WIN + 1);
   localparam int SUM_W = $clog2(WIN * WIN * 255 + 1) + 1;
   localparam int SQ_W  = $clog2(WIN * WIN * 65025 + 1);
   localparam int DIV_W = SQ_W;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd3;

   localparam logic [7:0] IMAGE_WIDTH_RST  = 8'd128;
   localparam logic [7:0] IMAGE_HEIGHT_RST = 8'd128;

   // result codes
   localparam logic [7:0]  NO_TARGET_MEAN     = 8'd255;
   localparam logic [15:0] NO_TARGET_CONTRAST = 16'hFFFF;
   localparam logic [15:0] CONTRAST_MAX       = 16'h7FFF;
   localparam logic [7:0]  MEAN_MAX           = 8'd255;

   typedef struct packed {
      logic accept_query;
      logic load_pixel;
      logic rd_center;
      logic win_start;
      logic win_step;
      logic start_div;
      logic fin1;
      logic out_stats;
      logic out_notgt;
   } lwmc_cmd_type;

   typedef struct packed {
      logic in_image;
      logic center_transp;
      logic win_last;
      logic div_done;
      logic out_busy;
   } lwmc_stat_type;

   // row-major store address
   function automatic logic [ADDR_W-1:0] pix_addr(input logic [ADDR_W-1:0] row,
                                                  input logic [ADDR_W-1:0] col);
      return ADDR_W'(row * MAX_WIDTH + col);
   endfunction

endpackage

// ----- sv/local_window_mean_contrast.sv -----
// top level of the local window mean and contrast block
//
// holds a grey image (up to 128 x 128 pixels, 9-bit signed, -1 transparent) in a
// single-port-write ram and answers window statistics queries. a load item
// (kind 0) writes one pixel and gives no result. a query item (kind 1) shifts
// (query_x, query_y) by the offset registers; if the point is off the image or
// transparent the result is mean 255, contrast -1. otherwise the controller
// walks all 121 positions of the 11 x 11 window, one position per cycle with a
// store read for each position inside the image, accumulating sum, sum of
// squares and count, then runs a bit-serial divider (one quotient bit per cycle,
// both sums in parallel) and finishes mean and variance in the FIN1 and FIN2
// states. one item is in flight at a time; the result sits in an output
// register so the next item is taken while it waits. the store has no reset
// and no clearing pass: read only pixels that were loaded. registers are
// written through csr_wr_en / csr_index / csr_wdata; the user must write them
// only while the block is idle, the block itself does not enforce this.
module local_window_mean_contrast
   import lwmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // item input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [6:0]            req_load_col,
   input  logic [6:0]            req_load_row,
   input  logic signed [8:0]     req_pixel_value,
   input  logic [7:0]            req_query_x,
   input  logic [7:0]            req_query_y,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_mean_level,
   output logic signed [15:0]    rsp_local_contrast,
   // register write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   lwmc_cmd_type  cmd;
   lwmc_stat_type stat;

   // state machine: item acceptance and query sequencing
   lwmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store, window accumulation, divider and result register
   lwmc_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_load_col       (req_load_col),
      .req_load_row       (req_load_row),
      .req_pixel_value    (req_pixel_value),
      .req_query_x        (req_query_x),
      .req_query_y        (req_query_y),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_mean_level     (rsp_mean_level),
      .rsp_local_contrast (rsp_local_contrast)
   );

endmodule

// ----- sv/lwmc_ram.sv -----
// generic single write port ram with registered read
module lwmc_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/lwmc_div.sv -----
// two-lane restoring divider, one quotient bit per cycle, shared divisor
module lwmc_div
   import lwmc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] divisor,
   input  logic [DIV_W-1:0] dividend_a,
   input  logic [DIV_W-1:0] dividend_b,
   output logic [DIV_W-1:0] quot_a,
   output logic [DIV_W-1:0] quot_b,
   output logic             done
);

   localparam int DCNT_W = $clog2(DIV_W + 1);

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  d_ff, d_in;
   logic [DIV_W-1:0]  qa_ff, qa_in, qb_ff, qb_in;
   logic [CNT_W-1:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [CNT_W:0]    step_a, step_b;

   // returns {quotient bit, new remainder}
   function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                               input logic             nb,
                                               input logic [CNT_W-1:0] d);
      logic [CNT_W:0] trial;
      trial = {rem, nb};
      if (trial >= {1'b0, d}) begin
         return {1'b1, CNT_W'(trial - {1'b0, d})};
      end
      return {1'b0, trial[CNT_W-1:0]};
   endfunction

   assign step_a = div_step(ra_ff, qa_ff[DIV_W-1], d_ff);
   assign step_b = div_step(rb_ff, qb_ff[DIV_W-1], d_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      d_in    = d_ff;
      qa_in   = qa_ff;
      qb_in   = qb_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      if (start) begin
         cnt_in  = DCNT_W'(DIV_W);
         done_in = 1'b0;
         d_in    = divisor;
         qa_in   = dividend_a;
         qb_in   = dividend_b;
         ra_in   = '0;
         rb_in   = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         qa_in  = {qa_ff[DIV_W-2:0], step_a[CNT_W]};
         qb_in  = {qb_ff[DIV_W-2:0], step_b[CNT_W]};
         ra_in  = step_a[CNT_W-1:0];
         rb_in  = step_b[CNT_W-1:0];
         if (cnt_ff == DCNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      d_ff  <= d_in;
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
   end

   assign quot_a = qa_ff;
   assign quot_b = qb_ff;
   assign done   = done_ff;

endmodule

// ----- sv/lwmc_dp.sv -----
// datapath: config registers, image store, window scan, accumulators, divider, result register
module lwmc_dp
   import lwmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  lwmc_cmd_type          cmd,
   output lwmc_stat_type         stat,
   input  logic [6:0]            req_load_col,
   input  logic [6:0]            req_load_row,
   input  logic signed [8:0]     req_pixel_value,
   input  logic [7:0]            req_query_x,
   input  logic [7:0]            req_query_y,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_mean_level,
   output logic signed [15:0]    rsp_local_contrast
);

   // config registers
   logic signed [8:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [7:0]        width_ff, width_in, height_ff, height_in;

   always_comb begin
      offx_in   = offx_ff;
      offy_in   = offy_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_X:     offx_in   = csr_wdata[8:0];
            CSR_OFFSET_Y:     offy_in   = csr_wdata[8:0];
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[7:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // image size clipped to the store
   logic signed [COORD_W-1:0] eff_w, eff_h;
   assign eff_w = (width_ff > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : COORD_W'(width_ff);
   assign eff_h = (height_ff > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(height_ff);

   // target point
   logic signed [COORD_W-1:0] tx_ff, tx_in, ty_ff, ty_in;

   always_comb begin
      tx_in = tx_ff;
      ty_in = ty_ff;
      if (cmd.accept_query) begin
         tx_in = $signed({{(COORD_W-8){1'b0}}, req_query_x})
               + $signed({{(COORD_W-9){offx_ff[8]}}, offx_ff});
         ty_in = $signed({{(COORD_W-8){1'b0}}, req_query_y})
               + $signed({{(COORD_W-9){offy_ff[8]}}, offy_ff});
      end
   end

   assign stat.in_image = (tx_ff >= 0) && (tx_ff < eff_w) && (ty_ff >= 0) && (ty_ff < eff_h);

   // window position counters
   logic [WIN_W-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic signed [COORD_W-1:0] dxo, dyo, win_col, win_row;
   logic                      win_in;

   assign dxo     = $signed(COORD_W'(dx_ff)) - $signed(COORD_W'(WINDOW_RADIUS));
   assign dyo     = $signed(COORD_W'(dy_ff)) - $signed(COORD_W'(WINDOW_RADIUS));
   assign win_col = tx_ff + dxo;
   assign win_row = ty_ff + dyo;
   assign win_in  = (win_col >= 0) && (win_col < eff_w) && (win_row >= 0) && (win_row < eff_h);

   assign stat.win_last = (dx_ff == WIN_W'(WIN - 1)) && (dy_ff == WIN_W'(WIN - 1));

   always_comb begin
      dx_in = dx_ff;
      dy_in = dy_ff;
      if (cmd.win_start) begin
         dx_in = '0;
         dy_in = '0;
      end else if (cmd.win_step) begin
         if (dx_ff == WIN_W'(WIN - 1)) begin
            dx_in = '0;
            dy_in = dy_ff + 1'b1;
         end else begin
            dx_in = dx_ff + 1'b1;
         end
      end
   end

   // image store
   logic                    st_wr_en, st_rd_en;
   logic [ADDR_W-1:0]       st_wr_addr, st_rd_addr, center_addr, win_addr;
   logic [PIX_W-1:0]        st_wr_data, st_rd_raw;
   logic signed [PIX_W-1:0] rd_pix;

   assign st_wr_en   = cmd.load_pixel && (32'(req_load_col) < MAX_WIDTH)
                     && (32'(req_load_row) < MAX_HEIGHT);
   assign st_wr_addr = pix_addr(ADDR_W'(req_load_row), ADDR_W'(req_load_col));
   // any negative level is stored as transparent
   assign st_wr_data = req_pixel_value[8] ? '1 : req_pixel_value;

   assign center_addr = pix_addr(ADDR_W'(ty_ff), ADDR_W'(tx_ff));
   assign win_addr    = pix_addr(ADDR_W'(win_row), ADDR_W'(win_col));
   assign st_rd_en    = cmd.rd_center || (cmd.win_step && win_in);
   assign st_rd_addr  = cmd.rd_center ? center_addr : win_addr;

   lwmc_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_raw)
   );

   assign rd_pix             = $signed(st_rd_raw);
   assign stat.center_transp = rd_pix[PIX_W-1];

   // accumulators, fed in the cycle after each window read
   logic                   pend_ff, pend_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic signed [2*PIX_W-1:0] prod;

   assign pend_in = cmd.win_step && win_in;
   assign prod    = rd_pix * rd_pix;

   always_comb begin
      sum_in = sum_ff;
      sq_in  = sq_ff;
      n_in   = n_ff;
      if (cmd.win_start) begin
         sum_in = '0;
         sq_in  = '0;
         n_in   = '0;
      end else if (pend_ff) begin
         sum_in = sum_ff + SUM_W'(rd_pix);
         sq_in  = sq_ff + SQ_W'($unsigned(prod));
         n_in   = n_ff + 1'b1;
      end
   end

   // division of both sums by the count
   logic [DIV_W-1:0] div_a, div_b, quot_a, quot_b;
   logic [CNT_W-1:0] divisor;

   assign div_a   = sum_ff[SUM_W-1] ? '0 : DIV_W'($unsigned(sum_ff));
   assign div_b   = sq_ff;
   assign divisor = (n_ff == '0) ? CNT_W'(1) : n_ff;

   lwmc_div u_div (
      .clock      (clock),
      .reset      (reset),
      .start      (cmd.start_div),
      .divisor    (divisor),
      .dividend_a (div_a),
      .dividend_b (div_b),
      .quot_a     (quot_a),
      .quot_b     (quot_b),
      .done       (stat.div_done)
   );

   // mean, its square, and the clamped variance
   logic [7:0]          avg_clip, avg_ff, avg_in;
   logic [15:0]         avgsq_ff, avgsq_in;
   logic signed [DIV_W:0] diff;
   logic [15:0]         contrast;

   assign avg_clip = (quot_a > DIV_W'(MEAN_MAX)) ? MEAN_MAX : quot_a[7:0];
   assign avg_in   = cmd.fin1 ? avg_clip : avg_ff;
   assign avgsq_in = cmd.fin1 ? 16'(avg_clip * avg_clip) : avgsq_ff;

   assign diff = $signed({1'b0, quot_b}) - $signed({{(DIV_W-15){1'b0}}, avgsq_ff});

   always_comb begin
      if (diff < 0) begin
         contrast = '0;
      end else if (diff > $signed({{(DIV_W-15){1'b0}}, CONTRAST_MAX})) begin
         contrast = CONTRAST_MAX;
      end else begin
         contrast = diff[15:0];
      end
   end

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  mean_ff, mean_in;
   logic [15:0] contr_ff, contr_in;

   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mean_in      = mean_ff;
      contr_in     = contr_ff;
      if (cmd.out_stats) begin
         rsp_valid_in = 1'b1;
         mean_in      = avg_ff;
         contr_in     = contrast;
      end else if (cmd.out_notgt) begin
         rsp_valid_in = 1'b1;
         mean_in      = NO_TARGET_MEAN;
         contr_in     = NO_TARGET_CONTRAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offx_ff      <= '0;
         offy_ff      <= '0;
         width_ff     <= IMAGE_WIDTH_RST;
         height_ff    <= IMAGE_HEIGHT_RST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sum_ff   <= sum_in;
      sq_ff    <= sq_in;
      n_ff     <= n_in;
      avg_ff   <= avg_in;
      avgsq_ff <= avgsq_in;
      mean_ff  <= mean_in;
      contr_ff <= contr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_level     = mean_ff;
   assign rsp_local_contrast = $signed(contr_ff);

endmodule

// ----- sv/lwmc_ctrl.sv -----
// controller: sequences loads, window scan, division and result hand-off
module lwmc_ctrl
   import lwmc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_stall,
   input  lwmc_stat_type stat,
   output lwmc_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CHECK  = 4'd1;
   localparam logic [3:0] ST_CENTER = 4'd2;
   localparam logic [3:0] ST_SCAN   = 4'd3;
   localparam logic [3:0] ST_DRAIN  = 4'd4;
   localparam logic [3:0] ST_START  = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_FIN1   = 4'd7;
   localparam logic [3:0] ST_FIN2   = 4'd8;
   localparam logic [3:0] ST_NOTGT  = 4'd9;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.accept_query = 1'b1;
                  state_in         = ST_CHECK;
               end else begin
                  cmd.load_pixel = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (stat.in_image) begin
               cmd.rd_center = 1'b1;
               state_in      = ST_CENTER;
            end else begin
               state_in = ST_NOTGT;
            end
         end
         ST_CENTER: begin
            if (stat.center_transp) begin
               state_in = ST_NOTGT;
            end else begin
               cmd.win_start = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.win_step = 1'b1;
            if (stat.win_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_START;
         ST_START: begin
            cmd.start_div = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_FIN1;
            end
         end
         ST_FIN1: begin
            cmd.fin1 = 1'b1;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            if (!stat.out_busy) begin
               cmd.out_stats = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_NOTGT: begin
            if (!stat.out_busy) begin
               cmd.out_notgt = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_stats || cmd.out_notgt) |-> !stat.out_busy)
      else $error("result loaded while previous item still held");

   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.start_div |=> !stat.div_done)
      else $error("divider done not cleared by start");

   a_div_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN2) |-> stat.div_done)
      else $error("divider quotient dropped before result formed");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(stat.win_last))
      else $error("window scan ended early");
`endif

endmodule
